### hdl/slt_pkg.sv
`default_nettype none

package slt_pkg;

	localparam int SLT_LENGTH_BITS = 8;
	localparam int NUM_WORDS = 12;

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_NUM   = 3'd1;
	localparam logic [2:0] M_STR   = 3'd2;
	localparam logic [2:0] M_IDENT = 3'd3;
	localparam logic [2:0] M_WS    = 3'd4;
	localparam logic [2:0] M_OP    = 3'd5;
	localparam logic [2:0] M_ANDOR = 3'd6;
	localparam logic [2:0] M_DOT   = 3'd7;

	localparam logic [3:0] K_NUMBER   = 4'd0;
	localparam logic [3:0] K_STRING   = 4'd1;
	localparam logic [3:0] K_IDENT    = 4'd2;
	localparam logic [3:0] K_KEYWORD  = 4'd3;
	localparam logic [3:0] K_BOOLEAN  = 4'd4;
	localparam logic [3:0] K_OPERATOR = 4'd5;
	localparam logic [3:0] K_SYMBOL   = 4'd6;
	localparam logic [3:0] K_WS       = 4'd7;
	localparam logic [3:0] K_UNDEF    = 4'd8;

	// word list, left aligned, first character in the top byte; the first two are booleans
	function automatic logic [39:0] word_str(input logic [3:0] k);
		logic [39:0] w;
		case (k)
			4'd0:    w = {"true", 8'h00};
			4'd1:    w = "false";
			4'd2:    w = {"if", 24'h0};
			4'd3:    w = {"else", 8'h00};
			4'd4:    w = "while";
			4'd5:    w = {"for", 16'h0};
			4'd6:    w = {"void", 8'h00};
			4'd7:    w = {"null", 8'h00};
			4'd8:    w = {"num", 16'h0};
			4'd9:    w = {"str", 16'h0};
			4'd10:   w = {"bool", 8'h00};
			4'd11:   w = "const";
			default: w = 40'h0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] word_len(input logic [3:0] k);
		logic [2:0] n;
		case (k)
			4'd0, 4'd3, 4'd6, 4'd7, 4'd10: n = 3'd4;
			4'd1, 4'd4, 4'd11:             n = 3'd5;
			4'd2:                          n = 3'd2;
			4'd5, 4'd8, 4'd9:              n = 3'd3;
			default:                       n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] word_chr(input logic [3:0] k, input logic [2:0] i);
		logic [39:0] w;
		w = word_str(k);
		return w[39 - 8 * i -: 8];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || c == 8'h09;
	endfunction

	function automatic logic is_opsym(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
			c == "%" || c == "=" || c == "!" || c == "<" || c == ">";
	endfunction

	function automatic logic is_langsym(input logic [7:0] c);
		return c == "{" || c == "}" || c == "(" || c == ")" || c == ";" ||
			c == "." || c == ",";
	endfunction

endpackage

`default_nettype wire

### hdl/script_lexer_token_classifier.sv
// Token classifier for a small scripting language.
// Input stream: one source byte per transaction on s_tdata; s_tlast marks the
// final byte and flushes whatever token is still open.
// Output stream: one token per transaction, kind and length on m_tdata;
// m_tlast is set on the last token caused by a given byte, m_tuser on the
// token that closes the whole input. A byte may give zero to three tokens.
// Path: an accepted byte is held in the input register and classified from
// there; its tokens are written into the result queue, which drives the
// output port.
// Throughput: one byte per cycle while the receiver keeps up and each byte
// gives at most one token. The output port moves one token per cycle; the
// four-entry result queue between the classifier register and the output
// port absorbs short bursts of multi-token bytes, and a sustained run of
// them holds the input for the extra cycles.
// A stalled receiver fills the queue; once it cannot take a byte's tokens the
// input deasserts s_tready. No token is dropped.
// Reset clears the open token, the input register and the queue; the block
// is ready to accept a byte as soon as reset is released.
`default_nettype none

module script_lexer_token_classifier
	import slt_pkg::*;
#(
	parameter int LENGTH_BITS = SLT_LENGTH_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [3:0] token_kind, [11:4] token_length, zero pad
	output logic             m_tlast,   // run_last
	output logic             m_tuser    // stream_done
);

	localparam int LB = LENGTH_BITS;
	localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

	typedef struct packed {
		logic [2:0]    mode;
		logic [LB-1:0] cnt;
		logic          sdot;
		logic          esc;
		logic          tdot;
		logic [7:0]    held;
		logic [11:0]   hits;
	} lex_t;

	typedef struct packed {
		logic [1:0]           n;
		logic [2:0][3:0]      kind;
		logic [2:0][LB-1:0]   len;
	} res_t;

	function automatic lex_t clear_fn();
		lex_t s;
		s.mode = M_IDLE;
		s.cnt  = '0;
		s.sdot = 1'b0;
		s.esc  = 1'b0;
		s.tdot = 1'b0;
		s.held = 8'h00;
		s.hits = 12'hFFF;
		return s;
	endfunction

	function automatic logic [LB-1:0] sat_inc(input logic [LB-1:0] v);
		return (v == LEN_MAX) ? v : v + LB'(1);
	endfunction

	function automatic logic [11:0] match_fn(input logic [11:0] hits, input logic [LB-1:0] cnt,
			input logic [7:0] c);
		logic [11:0] h;
		h = hits;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (cnt >= {{(LB-3){1'b0}}, word_len(4'(k))} ||
					word_chr(4'(k), cnt[2:0]) != c)
				h[k] = 1'b0;
		end
		return h;
	endfunction

	function automatic res_t add_res(input res_t r, input logic [3:0] kind,
			input logic [LB-1:0] len);
		res_t o;
		o = r;
		if (r.n != 2'd3) begin
			o.kind[r.n] = kind;
			o.len[r.n]  = len;
			o.n         = r.n + 2'd1;
		end
		return o;
	endfunction

	function automatic res_t flush_fn(input res_t r, input lex_t s);
		res_t o;
		logic [3:0] kind;
		o = r;
		kind = K_IDENT;
		case (s.mode)
			M_NUM: begin
				o = add_res(o, K_NUMBER, s.cnt - LB'(s.tdot));
				if (s.tdot)
					o = add_res(o, K_SYMBOL, LB'(1));
			end
			M_STR:   o = add_res(o, K_UNDEF, s.cnt);
			M_IDENT: begin
				for (int k = 0; k < NUM_WORDS; k++) begin
					if (s.hits[k] && s.cnt == {{(LB-3){1'b0}}, word_len(4'(k))})
						kind = (k < 2) ? K_BOOLEAN : K_KEYWORD;
				end
				o = add_res(o, kind, s.cnt);
			end
			M_WS:    o = add_res(o, K_WS, s.cnt);
			M_OP:    o = add_res(o, K_OPERATOR, LB'(1));
			M_ANDOR: o = add_res(o, K_UNDEF, LB'(1));
			M_DOT:   o = add_res(o, K_SYMBOL, LB'(1));
			default: o = r;
		endcase
		return o;
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	lex_t lex_q;
	lex_t nx;
	res_t res;
	logic go;
	logic do_close;
	logic do_start;

	// result queue
	logic [3:0]    bkind_q [4];
	logic [7:0]    blen_q  [4];
	logic          blast_q [4];
	logic          bdone_q [4];
	logic [1:0]    head_q;
	logic [2:0]    count_q;
	logic [2:0]    free;
	logic          pop;

	always_comb begin
		nx       = lex_q;
		res      = '0;
		do_close = 1'b0;
		do_start = 1'b0;
		case (lex_q.mode)
			M_NUM: begin
				if (is_digit(char_s1)) begin
					nx.cnt  = sat_inc(lex_q.cnt);
					nx.tdot = 1'b0;
				end else if (char_s1 == "." && !lex_q.sdot) begin
					nx.cnt  = sat_inc(lex_q.cnt);
					nx.sdot = 1'b1;
					nx.tdot = 1'b1;
				end else begin
					do_close = 1'b1;
				end
			end
			M_STR: begin
				nx.cnt = sat_inc(lex_q.cnt);
				if (lex_q.esc) begin
					nx.esc = 1'b0;
				end else if (char_s1 == "\\") begin
					nx.esc = 1'b1;
				end else if (char_s1 == "\"") begin
					res = add_res(res, K_STRING, nx.cnt);
					nx  = clear_fn();
				end
			end
			M_IDENT: begin
				if (is_letter(char_s1) || is_digit(char_s1) || char_s1 == "_") begin
					nx.hits = match_fn(lex_q.hits, lex_q.cnt, char_s1);
					nx.cnt  = sat_inc(lex_q.cnt);
				end else begin
					do_close = 1'b1;
				end
			end
			M_WS: begin
				if (is_space(char_s1))
					nx.cnt = sat_inc(lex_q.cnt);
				else
					do_close = 1'b1;
			end
			M_OP: begin
				if (char_s1 == "=") begin
					res = add_res(res, K_OPERATOR, LB'(2));
					nx  = clear_fn();
				end else begin
					do_close = 1'b1;
				end
			end
			M_ANDOR: begin
				if (char_s1 == lex_q.held) begin
					res = add_res(res, K_OPERATOR, LB'(2));
					nx  = clear_fn();
				end else begin
					do_close = 1'b1;
				end
			end
			M_DOT: begin
				if (is_digit(char_s1)) begin
					nx.mode = M_NUM;
					nx.sdot = 1'b1;
					nx.tdot = 1'b0;
					nx.cnt  = LB'(2);
				end else begin
					do_close = 1'b1;
				end
			end
			default: do_start = 1'b1;
		endcase

		if (do_close) begin
			res      = flush_fn(res, lex_q);
			do_start = 1'b1;
		end

		if (do_start) begin
			nx = clear_fn();
			if (is_space(char_s1)) begin
				nx.mode = M_WS;
				nx.cnt  = LB'(1);
			end else if (is_letter(char_s1) || char_s1 == "_") begin
				nx.mode = M_IDENT;
				nx.hits = match_fn(12'hFFF, '0, char_s1);
				nx.cnt  = LB'(1);
			end else if (is_digit(char_s1)) begin
				nx.mode = M_NUM;
				nx.cnt  = LB'(1);
			end else if (char_s1 == "\"") begin
				nx.mode = M_STR;
				nx.cnt  = LB'(1);
			end else if (char_s1 == "&" || char_s1 == "|") begin
				nx.mode = M_ANDOR;
				nx.held = char_s1;
			end else if (char_s1 == ".") begin
				nx.mode = M_DOT;
			end else if (is_langsym(char_s1)) begin
				res = add_res(res, K_SYMBOL, LB'(1));
			end else if (is_opsym(char_s1)) begin
				nx.mode = M_OP;
				nx.held = char_s1;
			end else begin
				res = add_res(res, K_UNDEF, LB'(1));
			end
		end

		if (eoi_s1) begin
			res = flush_fn(res, nx);
			nx  = clear_fn();
		end
	end

	assign free     = 3'd4 - count_q;
	assign go       = valid_s1 && ({1'b0, res.n} <= free);
	assign s_tready = !valid_s1 || go;
	assign m_tvalid = count_q != 3'd0;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q <= clear_fn();
		end else if (go) begin
			lex_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (pop)
				head_q <= head_q + 2'd1;
			count_q <= count_q + (go ? {1'b0, res.n} : 3'd0) - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		logic [1:0]    idx;
		logic [LB+7:0] ext;
		for (int i = 0; i < 3; i++) begin
			idx = head_q + count_q[1:0] + 2'(i);
			ext = {8'h00, res.len[i]};
			if (go && 2'(i) < res.n) begin
				bkind_q[idx] <= res.kind[i];
				blen_q[idx]  <= ext[7:0];
				blast_q[idx] <= (2'(i) == res.n - 2'd1);
				bdone_q[idx] <= (2'(i) == res.n - 2'd1) && eoi_s1;
			end
		end
	end

	assign m_tdata = {4'h0, blen_q[head_q], bkind_q[head_q]};
	assign m_tlast = blast_q[head_q];
	assign m_tuser = bdone_q[head_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overfilled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("stream end not on last token of its byte");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && eoi_s1 |=> lex_q.mode == M_IDLE && lex_q.cnt == '0)
		else $error("token left open after end of input");

	a_escape_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		lex_q.esc |-> lex_q.mode == M_STR)
		else $error("escape pending outside a string");

endmodule

`default_nettype wire

### tb/token_checker.sv
`timescale 1ns / 100ps

package lex_words_pkg;

	// reserved words; the first two are the boolean literals
	function automatic string word_text(input int k);
		case (k)
			0:       return "true";
			1:       return "false";
			2:       return "if";
			3:       return "else";
			4:       return "while";
			5:       return "for";
			6:       return "void";
			7:       return "null";
			8:       return "num";
			9:       return "str";
			10:      return "bool";
			default: return "const";
		endcase
	endfunction

endpackage

module token_checker
	import slt_pkg::*;
	import lex_words_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic        m_tuser,
	output int               errors,
	output int               outstanding
);

	localparam int unsigned LEN_MAX = (1 << SLT_LENGTH_BITS) - 1;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] len;
		logic       last;
		logic       done;
	} token_t;

	token_t      tokens_due[$];
	token_t      byte_tokens[$];
	token_t      got;

	logic [2:0]  mode;
	int unsigned run_len;
	logic        dot_seen;
	logic        esc_on;
	logic        dot_trail;
	logic [7:0]  held_c;
	logic [11:0] word_hits;

	function automatic logic c_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic c_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic c_blank(input logic [7:0] c);
		return c == " " || c == "\t";
	endfunction

	function automatic logic c_opchar(input logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "^", "%", "=", "!", "<", ">": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic c_langchar(input logic [7:0] c);
		case (c)
			"{", "}", "(", ")", ";", ".", ",": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_tok;
		mode = M_IDLE;
		run_len = 0;
		dot_seen = 1'b0;
		esc_on = 1'b0;
		dot_trail = 1'b0;
		held_c = 8'h00;
		word_hits = 12'hFFF;
	endtask

	task automatic put_tok(input logic [3:0] kind, input int unsigned len);
		token_t t;
		if (byte_tokens.size() < 3) begin
			t.kind = kind;
			t.len = 8'(len & LEN_MAX);
			t.last = 1'b0;
			t.done = 1'b0;
			byte_tokens.push_back(t);
		end
	endtask

	task automatic count_up;
		if (run_len < LEN_MAX)
			run_len++;
	endtask

	task automatic narrow_words(input logic [7:0] c);
		int k;
		string w;
		for (k = 0; k < 12; k++) begin
			w = word_text(k);
			if (word_hits[k] && (run_len >= w.len() || w[run_len] != c))
				word_hits[k] = 1'b0;
		end
	endtask

	task automatic close_tok;
		int k;
		string w;
		logic [3:0] kind;
		case (mode)
			M_NUM: begin
				put_tok(K_NUMBER, run_len - dot_trail);
				if (dot_trail)
					put_tok(K_SYMBOL, 1);
			end
			M_STR:   put_tok(K_UNDEF, run_len);
			M_IDENT: begin
				kind = K_IDENT;
				for (k = 0; k < 12; k++) begin
					w = word_text(k);
					if (word_hits[k] && run_len == w.len())
						kind = (k < 2) ? K_BOOLEAN : K_KEYWORD;
				end
				put_tok(kind, run_len);
			end
			M_WS:    put_tok(K_WS, run_len);
			M_OP:    put_tok(K_OPERATOR, 1);
			M_ANDOR: put_tok(K_UNDEF, 1);
			M_DOT:   put_tok(K_SYMBOL, 1);
			default: ;
		endcase
		clear_tok();
	endtask

	task automatic open_tok(input logic [7:0] c);
		clear_tok();
		if (c_blank(c)) begin
			mode = M_WS;
			run_len = 1;
		end else if (c_letter(c) || c == "_") begin
			mode = M_IDENT;
			narrow_words(c);
			run_len = 1;
		end else if (c_digit(c)) begin
			mode = M_NUM;
			run_len = 1;
		end else if (c == "\"") begin
			mode = M_STR;
			run_len = 1;
		end else if (c == "&" || c == "|") begin
			mode = M_ANDOR;
			held_c = c;
		end else if (c == ".") begin
			mode = M_DOT;
		end else if (c_langchar(c)) begin
			put_tok(K_SYMBOL, 1);
		end else if (c_opchar(c)) begin
			mode = M_OP;
			held_c = c;
		end else begin
			put_tok(K_UNDEF, 1);
		end
	endtask

	task automatic take_char(input logic [7:0] c);
		case (mode)
			M_NUM: begin
				if (c_digit(c)) begin
					count_up();
					dot_trail = 1'b0;
				end else if (c == "." && !dot_seen) begin
					count_up();
					dot_seen = 1'b1;
					dot_trail = 1'b1;
				end else begin
					close_tok();
					open_tok(c);
				end
			end
			M_STR: begin
				count_up();
				if (esc_on)
					esc_on = 1'b0;
				else if (c == "\\")
					esc_on = 1'b1;
				else if (c == "\"") begin
					put_tok(K_STRING, run_len);
					clear_tok();
				end
			end
			M_IDENT: begin
				if (c_letter(c) || c_digit(c) || c == "_") begin
					narrow_words(c);
					count_up();
				end else begin
					close_tok();
					open_tok(c);
				end
			end
			M_WS: begin
				if (c_blank(c))
					count_up();
				else begin
					close_tok();
					open_tok(c);
				end
			end
			M_OP: begin
				if (c == "=") begin
					put_tok(K_OPERATOR, 2);
					clear_tok();
				end else begin
					close_tok();
					open_tok(c);
				end
			end
			M_ANDOR: begin
				if (c == held_c) begin
					put_tok(K_OPERATOR, 2);
					clear_tok();
				end else begin
					close_tok();
					open_tok(c);
				end
			end
			M_DOT: begin
				if (c_digit(c)) begin
					mode = M_NUM;
					dot_seen = 1'b1;
					dot_trail = 1'b0;
					run_len = 2;
				end else begin
					close_tok();
					open_tok(c);
				end
			end
			default: open_tok(c);
		endcase
	endtask

	task automatic predict_byte(input logic [7:0] c, input logic eoi);
		token_t t;
		byte_tokens.delete();
		take_char(c);
		if (eoi)
			close_tok();
		if (byte_tokens.size() > 0) begin
			t = byte_tokens.pop_back();
			t.last = 1'b1;
			t.done = eoi;
			byte_tokens.push_back(t);
		end
		while (byte_tokens.size() > 0)
			tokens_due.push_back(byte_tokens.pop_front());
	endtask

	initial begin
		errors = 0;
		outstanding = 0;
		clear_tok();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					errors++;
					$error("unexpected token: kind %0d, length %0d", m_tdata[3:0], m_tdata[11:4]);
				end else begin
					got = tokens_due.pop_front();
					if (m_tdata[3:0] !== got.kind) begin
						errors++;
						$error("token_kind: expected %0d, got %0d", got.kind, m_tdata[3:0]);
					end
					if (m_tdata[11:4] !== got.len) begin
						errors++;
						$error("token_length: expected %0d, got %0d", got.len, m_tdata[11:4]);
					end
					if (m_tdata[15:12] !== 4'h0) begin
						errors++;
						$error("tdata pad: expected 0, got %0h", m_tdata[15:12]);
					end
					if (m_tlast !== got.last) begin
						errors++;
						$error("run_last: expected %0b, got %0b", got.last, m_tlast);
					end
					if (m_tuser !== got.done) begin
						errors++;
						$error("stream_done: expected %0b, got %0b", got.done, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
		end
		outstanding <= tokens_due.size();
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import slt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam string DIGITS = "0123456789";
	localparam string ID_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tready = 1'b0;
	wire logic        s_tready;
	wire logic        m_tvalid;
	wire logic [15:0] m_tdata;
	wire logic        m_tlast;
	wire logic        m_tuser;

	int          errors;
	int          outstanding;
	int          src_idle = 0;
	int          dst_idle = 0;
	int          cycles = 0;
	int          sent = 0;
	logic [7:0]  lex_buf[$];

	script_lexer_token_classifier u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	token_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b0;
		#2 clk = 1'b1;
	end

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= dst_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// reserved words; the first two are the boolean literals
	function automatic string word_text(input int k);
		case (k)
			0:       return "true";
			1:       return "false";
			2:       return "if";
			3:       return "else";
			4:       return "while";
			5:       return "for";
			6:       return "void";
			7:       return "null";
			8:       return "num";
			9:       return "str";
			10:      return "bool";
			default: return "const";
		endcase
	endfunction

	function automatic logic [7:0] pick(input string pool);
		return pool[$urandom_range(pool.len() - 1)];
	endfunction

	task automatic put_char(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic ship(input logic eoi);
		int i;
		for (i = 0; i < lex_buf.size(); i++)
			put_char(lex_buf[i], eoi && (i == lex_buf.size() - 1));
		lex_buf.delete();
	endtask

	task automatic send_text(input string s, input logic eoi);
		int i;
		for (i = 0; i < s.len(); i++)
			lex_buf.push_back(s[i]);
		ship(eoi);
	endtask

	task automatic wait_drain;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one lexeme, mostly well formed, some broken
	task automatic send_lexeme;
		int n;
		int i;
		string w;
		logic [7:0] c;
		case ($urandom_range(11))
			0: begin
				n = $urandom_range(1, 4);
				repeat (n) lex_buf.push_back(pick(DIGITS));
				if ($urandom_range(1))
					lex_buf.push_back(".");
				n = $urandom_range(0, 3);
				repeat (n) lex_buf.push_back(pick(DIGITS));
			end
			1: begin
				lex_buf.push_back(".");
				n = $urandom_range(0, 2);
				repeat (n) lex_buf.push_back(pick(DIGITS));
			end
			2: begin
				lex_buf.push_back("\"");
				n = $urandom_range(0, 5);
				repeat (n) begin
					c = 8'($urandom_range(255));
					if (c == "\"" || c == "\\" || $urandom_range(5) == 0)
						lex_buf.push_back("\\");
					lex_buf.push_back(c);
				end
				if ($urandom_range(7) != 0)
					lex_buf.push_back("\"");
			end
			3: begin
				w = word_text($urandom_range(11));
				n = ($urandom_range(3) == 0) ? w.len() - 1 : w.len();
				for (i = 0; i < n; i++)
					lex_buf.push_back(w[i]);
				if ($urandom_range(3) == 0)
					lex_buf.push_back(pick({ID_CHARS, DIGITS}));
			end
			4: begin
				lex_buf.push_back(pick(ID_CHARS));
				n = $urandom_range(0, 5);
				repeat (n) lex_buf.push_back(pick({ID_CHARS, DIGITS}));
			end
			5: begin
				lex_buf.push_back(pick("+-*/^%=!<>"));
				if ($urandom_range(1))
					lex_buf.push_back("=");
			end
			6: begin
				c = pick("&|");
				lex_buf.push_back(c);
				if ($urandom_range(2) != 0)
					lex_buf.push_back(c);
			end
			7: begin
				n = $urandom_range(1, 4);
				repeat (n) lex_buf.push_back(pick(" \t"));
			end
			8:  lex_buf.push_back(pick("{}();,"));
			9:  lex_buf.push_back(8'($urandom_range(255)));
			10: lex_buf.push_back($urandom_range(1) ? 8'($urandom_range(128, 255)) :
				8'($urandom_range(31)));
			default: begin
				lex_buf.push_back("=");
				lex_buf.push_back("=");
			end
		endcase
		ship($urandom_range(14) == 0);
	endtask

	initial begin
		int phase;
		src_idle = 29;
		dst_idle = 59;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// second dot, trailing dot, lone ampersand and bar, escaped quote,
		// keyword, compound operator, byte extremes, unterminated string
		send_text("1.2.3", 1'b0);
		send_text("7.&|x", 1'b0);
		send_text("\"\\\"\"", 1'b0);
		send_text("if>=", 1'b0);
		put_char(8'h00, 1'b0);
		put_char(8'hFF, 1'b0);
		send_text("\"z", 1'b1);
		s_tvalid <= 1'b0;
		wait_drain();

		for (phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 29 : (phase == 1) ? 59 : 0;
			dst_idle = (phase == 0) ? 59 : (phase == 1) ? 29 : 0;
			sent = 0;
			while (sent < 52)
				send_lexeme();
		end
		put_char(";", 1'b1);
		s_tvalid <= 1'b0;
		wait_drain();
		repeat (10) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
